// ===== src/life_cellular_automaton_step_unit_macros.svh =====
// Assertion macros for the checker file of the Life step unit.
// Depends on nothing; included by bare file name.
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_UNIT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the reset is low.
`define LIFESTEP_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Same, on the clk and arst_n of the enclosing scope.
`define LIFESTEP_ASSERT(lbl, prop, msg) \
	`LIFESTEP_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== src/lifestep_pkg.sv =====
// Shared types, constants and register codes of the Life step unit.
// Depends on nothing; every other file but the macro header imports it.
package lifestep_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 128;

	localparam int ROW_COUNT_W = 6;
	localparam int COL_COUNT_W = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int CELL_ROW_W  = 5;
	localparam int CELL_COL_W  = 7;

	localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 6'd25;
	localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 8'd80;
	localparam int MIN_ROWS = 1;
	localparam int MIN_COLS = 2;

	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1
	} cfg_reg_t;

	// One board column of the window: bit 0 north, bit 2 south.
	typedef logic [2:0] col_triple_t;

	// Bits 0..2 west column, 3..5 center column, 6..8 east column.
	typedef logic [8:0] window_t;

	localparam window_t MASK_WEST  = 9'h007;
	localparam window_t MASK_EAST  = 9'h1C0;
	localparam window_t MASK_NORTH = 9'h049;
	localparam window_t MASK_SOUTH = 9'h124;

	// One column entry of the row store, which holds two rows.
	typedef struct packed {
		logic middle;
		logic upper;
	} store_entry_t;

endpackage

// ===== src/lifestep_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on lifestep_pkg.
interface lifestep_in_if
	import lifestep_pkg::*;
();
	logic valid;
	logic ready;
	logic cell_alive;
	logic frame_start;

	modport source (output valid, output cell_alive, output frame_start, input ready);
	modport sink (input valid, input cell_alive, input frame_start, output ready);
endinterface

interface lifestep_out_if
	import lifestep_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  next_alive;
	logic [CELL_ROW_W-1:0] cell_row;
	logic [CELL_COL_W-1:0] cell_col;
	logic                  frame_end;

	modport source (output valid, output next_alive, output cell_row, output cell_col,
		output frame_end, input ready);
	modport sink (input valid, input next_alive, input cell_row, input cell_col,
		input frame_end, output ready);
endinterface

// ===== src/life_cellular_automaton_step_unit.sv =====
// Top level of the streaming Life step unit (birth on 3, survival on 2 or 3).
// Depends on lifestep_pkg, lifestep_if, lifestep_row_store, lifestep_cell, lifestep_rule.
//
//   port      | dir | carries
//   ----------+-----+------------------------------------------------
//   cell_in   | in  | cell_alive, frame_start, one board cell per item
//   cell_out  | out | next_alive, cell_row, cell_col, frame_end
//   cfg_*     | in  | row_count (index 0), col_count (index 1)
//
// One item is taken per clock while cell_in.ready is high; a result leaves after the item that
// completes its window, through the window stage register and then the output register.
// The row store is read one column ahead, so cell_in.ready drops in the cycle after each
// configuration write.
// A stalled output holds one result in a spare stage, and stops input flow only when both
// are full. Reset clears positions, window, handshake state and the row store's written
// flags, so columns never written since reset read as dead cells.
module life_cellular_automaton_step_unit
	import lifestep_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lifestep_in_if.sink            cell_in,
	lifestep_out_if.source         cell_out
);

	localparam int CIW = $clog2(MAX_COLS);
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int CXW = (CNW > COL_COUNT_W) ? CNW : COL_COUNT_W;
	localparam int RPW = $clog2(MAX_ROWS + 3);
	localparam int RXW = (RPW > ROW_COUNT_W) ? RPW : ROW_COUNT_W;

	function automatic logic [RPW-1:0] bump_row(input logic [RPW-1:0] r,
		input logic [RPW-1:0] lim);
		return (r >= lim) ? lim : RPW'(r + RPW'(1));
	endfunction

	logic [ROW_COUNT_W-1:0] row_count_q;
	logic [COL_COUNT_W-1:0] col_count_q;
	logic                   cfg_blk_q;

	logic [RXW-1:0] row_ext;
	logic [CXW-1:0] col_ext;
	logic [RPW-1:0] rows;
	logic [CNW-1:0] cols;
	logic [RPW-1:0] ir_lim;
	logic [CIW-1:0] cc_last;
	logic [RPW-1:0] row_last;

	logic [RPW-1:0] ir_q, ir_base, ir_cur, ir_nxt, cr;
	logic [CIW-1:0] ic_q, ic_base, ic_cur, ic_nxt, cc, rd_addr;

	logic         in_acc;
	logic         adv_out;
	logic         adv_s1;
	logic         alive_eff;
	logic         emit;
	logic         frame_end_c;
	store_entry_t rd_data;
	store_entry_t wr_data;
	col_triple_t  triple;
	col_triple_t  east_q;
	col_triple_t  center_q;
	window_t      win_new;
	window_t      win_mask;

	logic                  valid_s1;
	window_t               win_s1;
	logic [CELL_ROW_W-1:0] row_s1;
	logic [CELL_COL_W-1:0] col_s1;
	logic                  end_s1;
	logic                  rule_next;

	logic                  out_valid_q;
	logic                  next_alive_q;
	logic [CELL_ROW_W-1:0] cell_row_q;
	logic [CELL_COL_W-1:0] cell_col_q;
	logic                  frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			cfg_blk_q   <= 1'b0;
		end else begin
			cfg_blk_q <= cfg_wr_en;
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ROW_COUNT: row_count_q <= cfg_data[ROW_COUNT_W-1:0];
					REG_COL_COUNT: col_count_q <= cfg_data[COL_COUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		row_ext = RXW'(row_count_q);
		col_ext = CXW'(col_count_q);
		if (row_ext < RXW'(MIN_ROWS)) begin
			rows = RPW'(MIN_ROWS);
		end else if (row_ext > RXW'(MAX_ROWS)) begin
			rows = RPW'(MAX_ROWS);
		end else begin
			rows = RPW'(row_ext);
		end
		if (col_ext < CXW'(MIN_COLS)) begin
			cols = CNW'(MIN_COLS);
		end else if (col_ext > CXW'(MAX_COLS)) begin
			cols = CNW'(MAX_COLS);
		end else begin
			cols = CNW'(col_ext);
		end
		ir_lim   = RPW'(rows + RPW'(2));
		cc_last  = CIW'(cols - CNW'(1));
		row_last = RPW'(rows - RPW'(1));
	end

	assign in_acc  = cell_in.valid && cell_in.ready;
	assign adv_out = !out_valid_q || cell_out.ready;
	assign adv_s1  = !valid_s1 || adv_out;
	assign cell_in.ready = !cfg_blk_q && adv_s1;

	always_comb begin
		ir_base = cell_in.frame_start ? '0 : ir_q;
		ic_base = cell_in.frame_start ? '0 : ic_q;
		if (CNW'(ic_base) >= cols) begin
			ic_cur = '0;
			ir_cur = bump_row(ir_base, ir_lim);
		end else begin
			ic_cur = ic_base;
			ir_cur = ir_base;
		end

		alive_eff = (ir_cur < rows) && cell_in.cell_alive;
		triple    = {alive_eff, rd_data.middle, rd_data.upper};
		wr_data   = '{middle: alive_eff, upper: rd_data.middle};

		emit = 1'b0;
		if (ic_cur == '0) begin
			emit = (ir_cur >= RPW'(2));
			cr   = RPW'(ir_cur - RPW'(2));
			cc   = cc_last;
		end else begin
			emit = (ir_cur >= RPW'(1));
			cr   = RPW'(ir_cur - RPW'(1));
			cc   = CIW'(ic_cur - CIW'(1));
		end
		emit = emit && (cr < rows);

		if (CNW'(ic_cur) + CNW'(1) >= cols) begin
			ic_nxt = '0;
			ir_nxt = bump_row(ir_cur, ir_lim);
		end else begin
			ic_nxt = CIW'(ic_cur + CIW'(1));
			ir_nxt = ir_cur;
		end

		if (in_acc) begin
			rd_addr = ic_nxt;
		end else if (CNW'(ic_q) >= cols) begin
			rd_addr = '0;
		end else begin
			rd_addr = ic_q;
		end

		win_new  = {triple, east_q, center_q};
		win_mask = '0;
		if (cc == '0) begin
			win_mask = win_mask | MASK_WEST;
		end
		if (cc == cc_last) begin
			win_mask = win_mask | MASK_EAST;
		end
		if (cr == '0) begin
			win_mask = win_mask | MASK_NORTH;
		end
		if (cr == row_last) begin
			win_mask = win_mask | MASK_SOUTH;
		end
		frame_end_c = (cr == row_last) && (cc == cc_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q <= '0;
			ic_q <= '0;
		end else if (in_acc) begin
			ir_q <= ir_nxt;
			ic_q <= ic_nxt;
		end
	end

	lifestep_row_store #(
		.DEPTH (MAX_COLS),
		.AW    (CIW)
	) u_row_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc),
		.wr_addr (ic_cur),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lifestep_cell u_cell_east (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (in_acc),
		.col_in   (triple),
		.col_q    (east_q)
	);

	lifestep_cell u_cell_center (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (in_acc),
		.col_in   (east_q),
		.col_q    (center_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			win_s1 <= win_new & ~win_mask;
			row_s1 <= CELL_ROW_W'(cr);
			col_s1 <= CELL_COL_W'(cc);
			end_s1 <= frame_end_c;
		end
	end

	lifestep_rule u_rule (
		.win        (win_s1),
		.next_alive (rule_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			next_alive_q <= rule_next;
			cell_row_q   <= row_s1;
			cell_col_q   <= col_s1;
			frame_end_q  <= end_s1;
		end
	end

	assign cell_out.valid      = out_valid_q;
	assign cell_out.next_alive = next_alive_q;
	assign cell_out.cell_row   = cell_row_q;
	assign cell_out.cell_col   = cell_col_q;
	assign cell_out.frame_end  = frame_end_q;

endmodule

// ===== src/lifestep_row_store.sv =====
// Column-indexed store of the two rows above the input row.
// Depends on lifestep_pkg; one write and one registered read per cycle, and a written flag
// per column makes entries never written since reset read as dead cells.
module lifestep_row_store
	import lifestep_pkg::*;
#(
	parameter int DEPTH = MAX_COLS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [AW-1:0] wr_addr,
	input  store_entry_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output store_entry_t rd_data
);

	store_entry_t     mem [DEPTH];
	store_entry_t     rd_raw_q;
	logic [DEPTH-1:0] written_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule

// ===== src/lifestep_cell.sv =====
// One column cell of the 3x3 window chain; takes its neighbor's column on a shift.
// Depends on lifestep_pkg.
module lifestep_cell
	import lifestep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift_en,
	input  col_triple_t col_in,
	output col_triple_t col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

endmodule

// ===== src/lifestep_rule.sv =====
// Neighbor count and birth-on-three, survive-on-two-or-three decision.
// Depends on lifestep_pkg; purely combinational.
module lifestep_rule
	import lifestep_pkg::*;
(
	input  window_t win,
	output logic    next_alive
);

	logic [3:0] count;

	always_comb begin
		count = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) begin
				count = count + 4'(win[k]);
			end
		end
		if (win[4]) begin
			next_alive = (count == 4'(SURVIVE_COUNT)) || (count == 4'(BIRTH_COUNT));
		end else begin
			next_alive = (count == 4'(BIRTH_COUNT));
		end
	end

endmodule

// ===== src/lifestep_checker.sv =====
// Port-level checks of the Life step unit and the bind that attaches them.
// Depends on lifestep_pkg and the assertion macro header.
`include "life_cellular_automaton_step_unit_macros.svh"

module lifestep_checker
	import lifestep_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  next_alive,
	input logic [CELL_ROW_W-1:0] cell_row,
	input logic [CELL_COL_W-1:0] cell_col,
	input logic                  frame_end
);

	`LIFESTEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(next_alive) && $stable(cell_row) && $stable(cell_col) && $stable(frame_end), "Stalled result item changed.")
	`LIFESTEP_ASSERT(a_cfg_pause, cfg_wr_en |=> !in_ready, "Input item taken right after a configuration write.")
	`LIFESTEP_ASSERT(a_ready_cause, !in_ready && !$past(cfg_wr_en) |-> out_valid && !out_ready, "Input ready dropped without a stalled output.")
	`LIFESTEP_ASSERT(a_out_origin, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "Result item appeared without an accepted input item.")

endmodule

bind life_cellular_automaton_step_unit lifestep_checker u_lifestep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_wr_en  (cfg_wr_en),
	.in_valid   (cell_in.valid),
	.in_ready   (cell_in.ready),
	.out_valid  (cell_out.valid),
	.out_ready  (cell_out.ready),
	.next_alive (cell_out.next_alive),
	.cell_row   (cell_out.cell_row),
	.cell_col   (cell_out.cell_col),
	.frame_end  (cell_out.frame_end)
);
